/* hw/rtl/lz77_stream_decompressor_assert.svh */
// Assertion macros for the decompressor RTL.
// Depends on nothing; included by the modules that assert.
`ifndef LZ77_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ77_STREAM_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication under the synchronous reset.
`define LZSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lz77 decompressor: same-cycle check failed");

// Next-cycle implication under the synchronous reset.
`define LZSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lz77 decompressor: next-cycle check failed");

`endif

/* hw/rtl/lzsd_pkg.sv */
// Shared types and constants of the LZ77 stream decompressor.
// No dependencies.
package lzsd_pkg;

    localparam int HDR_BYTES       = 4;
    localparam int TOKENS_PER_FLAG = 8;
    localparam int DIST_W          = 12;
    localparam logic [4:0] MATCH_LEN_BIAS = 5'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FLAGS,
        PH_TOKEN,
        PH_MATCH2,
        PH_DONE,
        PH_COPY_RD,
        PH_COPY_WR
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } emit_t;

endpackage

/* hw/rtl/lzsd_hist_ram.sv */
// History RAM: one write port, one registered read port.
// No dependencies.
module lzsd_hist_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/lzsd_core.sv */
// Token parser and match copy sequencer around the history RAM.
// Depends on lzsd_pkg and lz77_stream_decompressor_assert.svh.
`include "lz77_stream_decompressor_assert.svh"

module lzsd_core
    import lzsd_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    input  logic          can_emit,
    output emit_t         emit,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata
);

    phase_t        state_reg, state_next;
    logic [23:0]   tl_reg, tl_next;
    logic [23:0]   bp_reg, bp_next;
    logic [7:0]    flags_reg, flags_next;
    logic [3:0]    ti_reg, ti_next;
    logic [7:0]    mfb_reg, mfb_next;
    logic [AW-1:0] hp_reg, hp_next;
    logic [AW-1:0] src_reg, src_next;
    logic [4:0]    len_reg, len_next;

    logic              s_acc;
    logic              do_emit;
    logic              tok_done;
    logic [7:0]        emit_byte;
    logic [23:0]       bp_inc;
    logic [3:0]        ti_inc;
    logic [DIST_W-1:0] match_dist;
    logic [1:0]        hdr_slot;

    assign bp_inc     = bp_reg + 24'd1;
    assign ti_inc     = ti_reg + 4'd1;
    assign match_dist = {mfb_reg[3:0], s_tdata} + DIST_W'(1);
    assign hdr_slot   = ti_reg[1:0] - 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_IDLE;
            tl_reg    <= '0;
            bp_reg    <= '0;
            flags_reg <= '0;
            ti_reg    <= '0;
            mfb_reg   <= '0;
            hp_reg    <= '0;
            src_reg   <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tl_reg    <= tl_next;
            bp_reg    <= bp_next;
            flags_reg <= flags_next;
            ti_reg    <= ti_next;
            mfb_reg   <= mfb_next;
            hp_reg    <= hp_next;
            src_reg   <= src_next;
            len_reg   <= len_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tl_next    = tl_reg;
        bp_next    = bp_reg;
        flags_next = flags_reg;
        ti_next    = ti_reg;
        mfb_next   = mfb_reg;
        hp_next    = hp_reg;
        src_next   = src_reg;
        len_next   = len_reg;
        do_emit    = 1'b0;
        tok_done   = 1'b0;
        emit_byte  = s_tdata;
        ram_re     = 1'b0;
        ram_raddr  = src_reg;
        s_tready   = (state_reg != PH_COPY_RD) && (state_reg != PH_COPY_WR) && can_emit;
        s_acc      = s_tvalid && s_tready;

        if (s_acc && s_tuser) begin
            bp_next    = '0;
            tl_next    = '0;
            flags_next = '0;
            ti_next    = 4'd1;
            mfb_next   = '0;
            state_next = PH_HEADER;
        end else begin
            case (state_reg)
                PH_HEADER: begin
                    if (s_acc) begin
                        case (hdr_slot)
                            2'd0:    tl_next[7:0]   = tl_reg[7:0]   | s_tdata;
                            2'd1:    tl_next[15:8]  = tl_reg[15:8]  | s_tdata;
                            2'd2:    tl_next[23:16] = tl_reg[23:16] | s_tdata;
                            default: tl_next        = tl_reg;
                        endcase
                        ti_next = ti_inc;
                        if (ti_inc >= 4'(HDR_BYTES)) begin
                            ti_next    = '0;
                            state_next = (tl_next == 24'd0) ? PH_DONE : PH_FLAGS;
                        end
                    end
                end
                PH_FLAGS: begin
                    if (s_acc) begin
                        flags_next = s_tdata;
                        ti_next    = '0;
                        state_next = PH_TOKEN;
                    end
                end
                PH_TOKEN: begin
                    if (s_acc) begin
                        if (flags_reg[3'd7 - ti_reg[2:0]]) begin
                            mfb_next   = s_tdata;
                            state_next = PH_MATCH2;
                        end else begin
                            do_emit  = 1'b1;
                            tok_done = 1'b1;
                        end
                    end
                end
                PH_MATCH2: begin
                    if (s_acc) begin
                        src_next   = hp_reg - AW'(match_dist);
                        len_next   = 5'(mfb_reg[7:4]) + MATCH_LEN_BIAS;
                        state_next = PH_COPY_RD;
                    end
                end
                PH_COPY_RD: begin
                    ram_re     = 1'b1;
                    state_next = PH_COPY_WR;
                end
                PH_COPY_WR: begin
                    if (can_emit) begin
                        do_emit   = 1'b1;
                        emit_byte = ram_rdata;
                        src_next  = src_reg + AW'(1);
                        len_next  = len_reg - 5'd1;
                        if ((len_reg == 5'd1) || (bp_inc == tl_reg)) begin
                            tok_done = 1'b1;
                        end else begin
                            state_next = PH_COPY_RD;
                        end
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end

        if (do_emit) begin
            hp_next = hp_reg + AW'(1);
            bp_next = bp_inc;
        end
        if (tok_done) begin
            ti_next = ti_inc;
            if (bp_inc == tl_reg) begin
                state_next = PH_DONE;
            end else if (ti_inc >= 4'(TOKENS_PER_FLAG)) begin
                state_next = PH_FLAGS;
            end else begin
                state_next = PH_TOKEN;
            end
        end

        ram_we     = do_emit;
        ram_waddr  = hp_reg;
        ram_wdata  = emit_byte;
        emit.valid = do_emit;
        emit.data  = emit_byte;
        emit.last  = bp_inc == tl_reg;
    end

    `LZSD_ASSERT_NOW(a_emit_has_room, aclk, aresetn, emit.valid, can_emit)
    `LZSD_ASSERT_NEXT(a_read_then_write, aclk, aresetn,
        state_reg == PH_COPY_RD, state_reg == PH_COPY_WR)
    `LZSD_ASSERT_NOW(a_copy_len_live, aclk, aresetn,
        state_reg == PH_COPY_WR, len_reg != 5'd0)
    `LZSD_ASSERT_NEXT(a_last_ends_stream, aclk, aresetn,
        emit.valid && emit.last, state_reg == PH_DONE)

endmodule

/* hw/rtl/lz77_stream_decompressor.sv */
// Top level of the LZ77 stream decompressor: core, history RAM, output register.
// Depends on lzsd_pkg, lzsd_hist_ram and lzsd_core.
//
//  channel | direction | tdata             | side band
//  s_      | in        | [7:0] data_byte   | tuser: start_req
//  m_      | out       | [7:0] out_byte    | tlast: last
//
// A literal leaves one output byte. After the second byte of a match, each
// copied byte is a history RAM read (PH_COPY_RD), then a write and output
// (PH_COPY_WR), for len of 3 to 18 bytes, cut short at the stream length.
// s_tready is low while a match is copied and while the output register holds
// a byte that is not taken.
// Reset is synchronous; the history RAM is not cleared.
module lz77_stream_decompressor
    import lzsd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] start_req
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    emit_t         emit;
    logic          can_emit;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;

    assign can_emit = !m_valid_reg || m_tready;

    lzsd_core #(
        .AW(AW)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .can_emit  (can_emit),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lzsd_hist_ram #(
        .DEPTH(HISTORY_DEPTH),
        .AW   (AW)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = emit.data;
            m_last_next  = emit.last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* tb/sv/lz77_stream_decompressor_tb.sv */
// Self-checking testbench for lz77_stream_decompressor: directed and random streams.
// Depends on lzsd_pkg and the lz77_stream_decompressor RTL; a local decoder predicts
// the random transfers and those of directed rows not marked fixed.
module lz77_stream_decompressor_tb;
    import lzsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT        = 1_000_000;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          HIST_SIZE    = 4096;
    localparam int          DIR_ROWS     = 26;

    typedef struct packed {
        logic [7:0] data;
        logic       tail;
    } out_t;

    typedef struct packed {
        logic       st;
        logic [7:0] b;
        logic       fixed;
        logic       one_out;
        logic [7:0] ob;
        logic       ol;
    } dir_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // decoder state
    logic [7:0]  hist_mem [HIST_SIZE];
    logic [11:0] hist_ptr = '0;
    int          hist_fill = 0;
    logic [23:0] produced = '0;
    logic [23:0] total = '0;
    logic [7:0]  flags = '0;
    logic [3:0]  tok_idx = '0;
    logic [7:0]  mfb = '0;
    phase_t      phase = PH_IDLE;

    out_t        decoded [$];
    out_t        pending_out [$];
    out_t        want;
    int          mismatches = 0;
    int unsigned cycles = 0;
    int unsigned sink_hold = 0;
    bit          steady = 1'b0;

    logic [23:0] stream_len = '0;
    logic [11:0] copy_back = '0;
    dir_row_t    directed_rows [DIR_ROWS];

    lz77_stream_decompressor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [0] start_req
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_byte
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned gap_len();
        if ($urandom_range(99, 0) < 80)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [23:0] pick_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 8)
            return 24'd0;
        if (r < 40)
            return 24'($urandom_range(16, 1));
        if (r < 90)
            return 24'($urandom_range(300, 17));
        return 24'($urandom_range(1200, 301));
    endfunction

    task automatic put_byte(input logic [7:0] b);
        hist_mem[hist_ptr] = b;
        hist_ptr = hist_ptr + 12'd1;
        produced = produced + 24'd1;
        if (hist_fill < HIST_SIZE)
            hist_fill++;
        decoded.push_back('{data: b, tail: (produced == total)});
    endtask

    task automatic end_token();
        tok_idx = tok_idx + 4'd1;
        if (produced == total)
            phase = PH_DONE;
        else if (tok_idx >= 4'd8)
            phase = PH_FLAGS;
        else
            phase = PH_TOKEN;
    endtask

    task automatic decode_byte(input logic st, input logic [7:0] b);
        logic [12:0] back_dist;
        logic [11:0] src;
        logic [4:0]  len;
        int          k;
        decoded.delete();
        if (st) begin
            produced = '0;
            total    = '0;
            flags    = '0;
            tok_idx  = 4'd1;
            mfb      = '0;
            phase    = PH_HEADER;
        end else begin
            case (phase)
                PH_HEADER: begin
                    total = total | ({16'd0, b} << (8 * (tok_idx - 4'd1)));
                    tok_idx = tok_idx + 4'd1;
                    if (tok_idx >= 4'd4) begin
                        tok_idx = '0;
                        phase = (total == 24'd0) ? PH_DONE : PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    flags   = b;
                    tok_idx = '0;
                    phase   = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (flags[3'd7 - tok_idx[2:0]]) begin
                        mfb   = b;
                        phase = PH_MATCH2;
                    end else begin
                        put_byte(b);
                        end_token();
                    end
                end
                PH_MATCH2: begin
                    back_dist = {1'b0, mfb[3:0], b} + 13'd1;
                    len  = {1'b0, mfb[7:4]} + MATCH_LEN_BIAS;
                    for (k = 0; k < len && produced != total; k++) begin
                        src = hist_ptr - back_dist[11:0];
                        put_byte(hist_mem[src]);
                    end
                    end_token();
                end
                default: ;
            endcase
        end
    endtask

    // Build the next input byte from the decoder phase so most streams stay well formed.
    task automatic pick_next(output logic st, output logic [7:0] b, output bit counts);
        int i;
        counts = 1'b1;
        st = 1'b0;
        b = 8'($urandom_range(255, 0));
        if (phase == PH_IDLE || phase == PH_DONE) begin
            if ($urandom_range(99, 0) < 15)
                counts = 1'b0;
            else
                st = 1'b1;
        end else if ($urandom_range(99, 0) < 3) begin
            st = 1'b1;
        end else begin
            case (phase)
                PH_HEADER: b = stream_len[8 * (tok_idx - 4'd1) +: 8];
                PH_FLAGS: begin
                    for (i = 0; i < 8; i++)
                        b[i] = ($urandom_range(9, 0) < 7);
                    if (hist_fill == 0)
                        b[7] = 1'b0;
                end
                PH_TOKEN: begin
                    if (flags[3'd7 - tok_idx[2:0]]) begin
                        if ($urandom_range(9, 0) < 7)
                            copy_back = 12'($urandom_range((hist_fill < 16 ? hist_fill : 16) - 1, 0));
                        else
                            copy_back = 12'($urandom_range(hist_fill - 1, 0));
                        b[7:4] = $urandom_range(1, 0) ? 4'hF : 4'($urandom_range(15, 0));
                        b[3:0] = copy_back[11:8];
                    end
                end
                PH_MATCH2: b = copy_back[7:0];
                default: ;
            endcase
        end
        if (st)
            stream_len = pick_len();
    endtask

    task automatic send_byte(input logic st, input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= st;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic idle_after(input bit pause);
        int unsigned hold;
        hold = (steady || $urandom_range(99, 0) < 60) ? 0 : gap_len();
        if (pause && hold == 0)
            hold = 1;
        if (hold != 0) begin
            s_tvalid <= 1'b0;
            repeat (hold) @(posedge aclk);
            while (pause && pending_out.size() != 0)
                @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_tready && !steady && $urandom_range(3, 0) == 0) begin
            m_tready  <= 1'b0;
            sink_hold <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual out_byte %02h last %0b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_out.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.tail) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.tail, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("lz77_stream_decompressor_tb: errors");
            $finish;
        end
    end

    initial begin
        logic st;
        logic [7:0] b;
        bit counts;
        int done_items;
        int r;

        directed_rows = '{
            '{1'b0, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b0},   // no start yet: ignored
            '{1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},   // start, value ignored
            '{1'b0, 8'h05, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},   // length 5
            '{1'b0, 8'h20, 1'b1, 1'b0, 8'h00, 1'b0},   // third token is a match
            '{1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
            '{1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0},
            '{1'b0, 8'h10, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},   // match cut at the length
            '{1'b0, 8'h33, 1'b1, 1'b0, 8'h00, 1'b0},   // past the end: ignored
            '{1'b1, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},   // zero length
            '{1'b0, 8'h77, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b1, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},   // maximum length
            '{1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},   // all matches
            '{1'b0, 8'hF0, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},   // longest match, overlapped
            '{1'b0, 8'h50, 1'b1, 1'b0, 8'h00, 1'b0},
            '{1'b0, 8'h13, 1'b0, 1'b0, 8'h00, 1'b0},   // reaches into the previous stream
            '{1'b1, 8'hC3, 1'b1, 1'b0, 8'h00, 1'b0}    // start abandons the stream
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIR_ROWS; r++) begin
            send_byte(directed_rows[r].st, directed_rows[r].b);
            decode_byte(directed_rows[r].st, directed_rows[r].b);
            if (!directed_rows[r].fixed)
                foreach (decoded[i]) pending_out.push_back(decoded[i]);
            else if (directed_rows[r].one_out)
                pending_out.push_back('{data: directed_rows[r].ob, tail: directed_rows[r].ol});
            idle_after(r == DIR_ROWS - 1);
        end

        stream_len = pick_len();
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            if ($urandom_range(99, 0) < 2)
                steady = ~steady;
            pick_next(st, b, counts);
            send_byte(st, b);
            decode_byte(st, b);
            foreach (decoded[i]) pending_out.push_back(decoded[i]);
            if (counts)
                done_items++;
            idle_after($urandom_range(99, 0) == 0);
        end
        s_tvalid <= 1'b0;

        while (pending_out.size() != 0)
            @(posedge aclk);
        repeat (48) @(posedge aclk);

        if (mismatches == 0)
            $display("lz77_stream_decompressor_tb: clean");
        else
            $display("lz77_stream_decompressor_tb: errors");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_hist_ram.sv
hw/rtl/lzsd_core.sv
hw/rtl/lz77_stream_decompressor.sv
tb/sv/lz77_stream_decompressor_tb.sv
